// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define UDL_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("uop dependency list check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define UDL_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("uop dependency list check failed");

`endif

// File: sv/udl_pkg.sv
package udl_pkg;

	localparam int LIST_DEPTH = 8;
	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CNT_W = $clog2(LIST_DEPTH + 1);
	// common width for small count compares
	localparam int CW = 8;

	localparam logic [1:0] KIND_ADD = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_GET = 2'd2;
	localparam logic [1:0] KIND_RESTART = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_DUP = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_RANGE = 3'd4;

	localparam logic [1:0] CFG_OWN_SEQUENCE = 2'd0;
	localparam logic [1:0] CFG_TYPE_OFFSET = 2'd1;
	localparam logic [1:0] CFG_IMPLICIT_INITIAL = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [63:0] seq_value;
		logic [4:0] entry_index;
	} udl_in_t;

	typedef struct packed {
		logic [63:0] dep_value;
		logic [2:0] status;
		logic [3:0] implicit_left;
		logic [3:0] explicit_count;
	} udl_out_t;

	typedef struct packed {
		logic wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [63:0] wr_data;
		logic rd_en;
		logic [IDX_W-1:0] rd_addr;
	} udl_ram_req_t;

endpackage

// File: sv/udl_ram.sv
module udl_ram import udl_pkg::*; (
	input logic clk,
	input udl_ram_req_t req,
	output logic [63:0] rd_data
);

	logic [63:0] mem_q [LIST_DEPTH];
	logic [63:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem_q[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: sv/udl_seq.sv
module udl_seq import udl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input udl_in_t item,
	input logic [63:0] own_sequence,
	input logic [7:0] type_offset,
	input logic [3:0] implicit_initial,
	input logic [63:0] rd_data,
	output udl_ram_req_t ram_req,
	output logic busy,
	output logic done,
	output udl_out_t result
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_BASE = 3'd1;
	localparam logic [2:0] S_CLASS = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_DEC = 3'd4;
	localparam logic [2:0] S_MOVE = 3'd5;
	localparam logic [2:0] S_GETD = 3'd6;
	localparam logic [2:0] S_RESP = 3'd7;

	logic [2:0] state_q, state_d;
	logic [3:0] ic_q, ic_d;
	logic [CNT_W-1:0] len_q, len_d;
	logic done_q, done_d;
	logic vld_s1, vld_d;

	logic [1:0] kind_q, kind_d;
	logic [63:0] val_q, val_d;
	logic [4:0] idx_q, idx_d;
	logic [63:0] ob_q, ob_d;
	logic [63:0] base_q, base_d;
	logic [2:0] status_q, status_d;
	logic [63:0] dep_q, dep_d;
	logic [3:0] k_q, k_d;
	logic [63:0] mv_val_q, mv_val_d;
	logic [3:0] mv_cnt_q, mv_cnt_d;
	logic [CNT_W-1:0] rd_ptr_q, rd_ptr_d;
	logic [IDX_W-1:0] idx_s1, idx_s1_d;
	logic found_q, found_d;
	logic [IDX_W-1:0] pos_q, pos_d;
	logic last_hit_q, last_hit_d;
	logic [63:0] last_val_q, last_val_d;
	udl_out_t res_q, res_d;

	logic [63:0] diff;
	logic is_impl;
	logic k_big;
	logic [4:0] jdx;
	logic hit;

	assign diff = val_q - base_q;
	assign is_impl = (val_q >= base_q);
	assign k_big = (diff >= 64'(ic_q));
	assign jdx = idx_q - 5'(ic_q);
	assign hit = (rd_data == val_q);

	always_comb begin
		state_d = state_q;
		ic_d = ic_q;
		len_d = len_q;
		done_d = 1'b0;
		vld_d = vld_s1;
		kind_d = kind_q;
		val_d = val_q;
		idx_d = idx_q;
		ob_d = ob_q;
		base_d = base_q;
		status_d = status_q;
		dep_d = dep_q;
		k_d = k_q;
		mv_val_d = mv_val_q;
		mv_cnt_d = mv_cnt_q;
		rd_ptr_d = rd_ptr_q;
		idx_s1_d = idx_s1;
		found_d = found_q;
		pos_d = pos_q;
		last_hit_d = last_hit_q;
		last_val_d = last_val_q;
		res_d = res_q;
		ram_req = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					kind_d = item.kind;
					val_d = item.seq_value;
					idx_d = item.entry_index;
					ob_d = own_sequence - 64'(type_offset);
					status_d = ST_OK;
					dep_d = '0;
					if (item.kind == KIND_RESTART) begin
						ic_d = implicit_initial;
						len_d = '0;
						state_d = S_RESP;
					end else begin
						state_d = S_BASE;
					end
				end
			end
			S_BASE: begin
				base_d = ob_q - 64'(ic_q);
				rd_ptr_d = '0;
				vld_d = 1'b0;
				found_d = 1'b0;
				last_hit_d = 1'b0;
				state_d = (kind_q == KIND_ADD) ? S_SCAN : S_CLASS;
			end
			S_CLASS: begin
				if (kind_q == KIND_REMOVE) begin
					if (is_impl) begin
						if (k_big) begin
							status_d = ST_NOTFOUND;
							state_d = S_RESP;
						end else if ((CW'(len_q) + CW'(diff[3:0])) > CW'(LIST_DEPTH)) begin
							status_d = ST_FULL;
							state_d = S_RESP;
						end else begin
							k_d = diff[3:0];
							mv_cnt_d = diff[3:0];
							mv_val_d = base_q;
							state_d = S_MOVE;
						end
					end else if (len_q == '0) begin
						status_d = ST_NOTFOUND;
						state_d = S_RESP;
					end else begin
						state_d = S_SCAN;
					end
				end else begin
					if (idx_q < 5'(ic_q)) begin
						dep_d = base_q + 64'(idx_q);
						state_d = S_RESP;
					end else if (CW'(jdx) < CW'(len_q)) begin
						ram_req.rd_en = 1'b1;
						ram_req.rd_addr = jdx[IDX_W-1:0];
						state_d = S_GETD;
					end else begin
						status_d = ST_RANGE;
						state_d = S_RESP;
					end
				end
			end
			S_SCAN: begin
				if (rd_ptr_q != len_q) begin
					ram_req.rd_en = 1'b1;
					ram_req.rd_addr = rd_ptr_q[IDX_W-1:0];
					rd_ptr_d = rd_ptr_q + 1'b1;
					vld_d = 1'b1;
					idx_s1_d = rd_ptr_q[IDX_W-1:0];
				end else begin
					vld_d = 1'b0;
				end
				if (vld_s1) begin
					if (hit && !found_q) begin
						found_d = 1'b1;
						pos_d = idx_s1;
					end
					if (CNT_W'(idx_s1) == len_q - 1'b1) begin
						last_val_d = rd_data;
						last_hit_d = hit;
					end
				end
				if (rd_ptr_q == len_q && !vld_s1) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (kind_q == KIND_ADD) begin
					if (found_q) begin
						status_d = ST_DUP;
					end else if (len_q >= CNT_W'(LIST_DEPTH)) begin
						status_d = ST_FULL;
					end else begin
						ram_req.wr_en = 1'b1;
						ram_req.wr_addr = len_q[IDX_W-1:0];
						ram_req.wr_data = val_q;
						len_d = len_q + 1'b1;
					end
				end else begin
					if (last_hit_q) begin
						len_d = len_q - 1'b1;
					end else if (found_q) begin
						ram_req.wr_en = 1'b1;
						ram_req.wr_addr = pos_q;
						ram_req.wr_data = last_val_q;
						len_d = len_q - 1'b1;
					end else begin
						status_d = ST_NOTFOUND;
					end
				end
				state_d = S_RESP;
			end
			S_MOVE: begin
				if (mv_cnt_q == '0) begin
					ic_d = ic_q - k_q - 4'd1;
					state_d = S_RESP;
				end else begin
					ram_req.wr_en = 1'b1;
					ram_req.wr_addr = len_q[IDX_W-1:0];
					ram_req.wr_data = mv_val_q;
					len_d = len_q + 1'b1;
					mv_val_d = mv_val_q + 64'd1;
					mv_cnt_d = mv_cnt_q - 4'd1;
				end
			end
			S_GETD: begin
				dep_d = rd_data;
				state_d = S_RESP;
			end
			S_RESP: begin
				res_d.dep_value = dep_q;
				res_d.status = status_q;
				res_d.implicit_left = ic_q;
				res_d.explicit_count = 4'(len_q);
				done_d = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ic_q <= '0;
			len_q <= '0;
			done_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			ic_q <= ic_d;
			len_q <= len_d;
			done_q <= done_d;
			vld_s1 <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_d;
		val_q <= val_d;
		idx_q <= idx_d;
		ob_q <= ob_d;
		base_q <= base_d;
		status_q <= status_d;
		dep_q <= dep_d;
		k_q <= k_d;
		mv_val_q <= mv_val_d;
		mv_cnt_q <= mv_cnt_d;
		rd_ptr_q <= rd_ptr_d;
		idx_s1 <= idx_s1_d;
		found_q <= found_d;
		pos_q <= pos_d;
		last_hit_q <= last_hit_d;
		last_val_q <= last_val_d;
		res_q <= res_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = res_q;

endmodule

// File: sv/uop_dependency_list.sv
// channel   direction  handshake                 word
// item      in         start high, busy low      udl_in_t
// result    out        done strobe, one cycle    udl_out_t
// config    in         cfg_valid and cfg_ready   cfg_index, cfg_data
//
// restart goes from accept straight to the response; get reads at most one list entry
// implicit remove writes one list entry per value moved, and moves none when refused
// add and explicit remove scan the whole list; explicit remove skips the scan when the list is empty
// one list entry is scanned a cycle; busy is low only when idle, also while done is high
// arst_n clears the state, the counts and the config registers; list entries are undefined until written
// results cannot be held off; cfg_ready is always high

`include "assert_macros.svh"

module uop_dependency_list import udl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input udl_in_t item,
	output logic done,
	output udl_out_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [63:0] cfg_data
);

	logic [63:0] own_sequence_q;
	logic [7:0] type_offset_q;
	logic [3:0] implicit_initial_q;
	logic [63:0] rd_data;
	udl_ram_req_t ram_req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_sequence_q <= '0;
			type_offset_q <= '0;
			implicit_initial_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_OWN_SEQUENCE: own_sequence_q <= cfg_data;
				CFG_TYPE_OFFSET: type_offset_q <= cfg_data[7:0];
				CFG_IMPLICIT_INITIAL: implicit_initial_q <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	udl_ram u_ram (
		.clk(clk),
		.req(ram_req),
		.rd_data(rd_data)
	);

	udl_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.own_sequence(own_sequence_q),
		.type_offset(type_offset_q),
		.implicit_initial(implicit_initial_q),
		.rd_data(rd_data),
		.ram_req(ram_req),
		.busy(busy),
		.done(done),
		.result(result)
	);

	`UDL_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	`UDL_ASSERT_IMP(a_done_idle, done, !busy)
	`UDL_ASSERT_IMP(a_range_zero, done && result.status == ST_RANGE, result.dep_value == '0)
	`UDL_ASSERT_IMP(a_count_bound, done, CW'(result.explicit_count) <= CW'(LIST_DEPTH))

endmodule

// File: tb/sv/dep_list_checker.sv
module dep_list_checker import udl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input udl_in_t item,
	input logic done,
	input udl_out_t result,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [63:0] cfg_data,
	output int mismatches,
	output int pending
);

	logic [63:0] own_seq;
	logic [7:0] type_off;
	logic [3:0] imp_init;
	logic [3:0] imp_cnt;
	logic [3:0] list_len;
	logic [63:0] dep_list [LIST_DEPTH];
	udl_out_t expected_results [$];
	udl_out_t oldest;

	function automatic int find_entry(logic [63:0] value);
		for (int i = 0; i < list_len; i++) begin
			if (dep_list[i] == value)
				return i;
		end
		return -1;
	endfunction

	function automatic udl_out_t apply_dep_op(udl_in_t w);
		udl_out_t r;
		logic [63:0] base;
		logic [63:0] k;
		int pos;
		int last;
		int rel;
		r = '0;
		r.status = ST_OK;
		base = own_seq - 64'(type_off) - 64'(imp_cnt);
		case (w.kind)
			KIND_ADD: begin
				if (find_entry(w.seq_value) >= 0) begin
					r.status = ST_DUP;
				end else if (list_len >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					dep_list[list_len] = w.seq_value;
					list_len++;
				end
			end
			KIND_REMOVE: begin
				if (w.seq_value >= base) begin
					// implicit range: lower entries spill into the list
					k = w.seq_value - base;
					if (k >= 64'(imp_cnt)) begin
						r.status = ST_NOTFOUND;
					end else if (64'(list_len) + k > 64'(LIST_DEPTH)) begin
						r.status = ST_FULL;
					end else begin
						for (int i = 0; i < int'(k); i++) begin
							dep_list[list_len] = base + 64'(i);
							list_len++;
						end
						imp_cnt = imp_cnt - 4'(k + 64'd1);
					end
				end else if (list_len == 0) begin
					r.status = ST_NOTFOUND;
				end else begin
					last = int'(list_len) - 1;
					if (dep_list[last] == w.seq_value) begin
						list_len--;
					end else begin
						pos = find_entry(w.seq_value);
						if (pos < 0) begin
							r.status = ST_NOTFOUND;
						end else begin
							dep_list[pos] = dep_list[last];
							dep_list[last] = w.seq_value;
							list_len--;
						end
					end
				end
			end
			KIND_GET: begin
				rel = int'(w.entry_index) - int'(imp_cnt);
				if (rel < 0)
					r.dep_value = base + 64'(w.entry_index);
				else if (rel < int'(list_len))
					r.dep_value = dep_list[rel];
				else
					r.status = ST_RANGE;
			end
			KIND_RESTART: begin
				imp_cnt = imp_init;
				list_len = '0;
			end
			default: ;
		endcase
		r.implicit_left = imp_cnt;
		r.explicit_count = list_len;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_seq = '0;
			type_off = '0;
			imp_init = '0;
			imp_cnt = '0;
			list_len = '0;
			foreach (dep_list[i])
				dep_list[i] = '0;
			expected_results.delete();
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_OWN_SEQUENCE: own_seq = cfg_data;
					CFG_TYPE_OFFSET: type_off = cfg_data[7:0];
					CFG_IMPLICIT_INITIAL: imp_init = cfg_data[3:0];
					default: ;
				endcase
			end
			if (done) begin
				if (expected_results.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: result word with none expected: %h", $time, result);
					mismatches <= mismatches + 1;
				end else begin
					oldest = expected_results.pop_front();
					if (result.dep_value !== oldest.dep_value ||
							result.status !== oldest.status ||
							result.implicit_left !== oldest.implicit_left ||
							result.explicit_count !== oldest.explicit_count) begin
						if (mismatches < 10)
							$display({"%0t: mismatch exp/got dep_value %h/%h status %0d/%0d",
								" implicit_left %0d/%0d explicit_count %0d/%0d"}, $time,
								oldest.dep_value, result.dep_value,
								oldest.status, result.status,
								oldest.implicit_left, result.implicit_left,
								oldest.explicit_count, result.explicit_count);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (start && !busy)
				expected_results.push_back(apply_dep_op(item));
			pending <= expected_results.size();
		end
	end

endmodule

// File: tb/sv/tb_uop_dependency_list.sv
module tb_uop_dependency_list;
	import udl_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int POOL_SIZE = 12;
	localparam int PHASE_ITEMS = 110;
	localparam logic [1:0] CFG_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	udl_in_t item = '0;
	logic cfg_valid = 1'b0;
	logic [1:0] cfg_index = CFG_OWN_SEQUENCE;
	logic [63:0] cfg_data = '0;
	logic busy;
	logic done;
	logic cfg_ready;
	udl_out_t result;
	int mismatches;
	int pending;
	int cycles = 0;

	logic [63:0] cur_own;
	logic [7:0] cur_off;
	logic [63:0] seq_pool [POOL_SIZE];

	always #6 clk = ~clk;

	uop_dependency_list u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	dep_list_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_uop_dependency_list: FAIL");
			$finish;
		end
	end

	function automatic udl_in_t dep_op(logic [1:0] kind, logic [63:0] value, logic [4:0] idx);
		udl_in_t w;
		w.kind = kind;
		w.seq_value = value;
		w.entry_index = idx;
		return w;
	endfunction

	function automatic udl_in_t random_dep_op();
		udl_in_t w;
		int pick;
		int sel;
		w.kind = 2'($urandom_range(0, 3));
		w.seq_value = {$urandom, $urandom};
		w.entry_index = 5'($urandom_range(0, 31));
		pick = $urandom_range(0, 99);
		sel = $urandom_range(0, 9);
		if (pick < 8) begin
			w.kind = KIND_RESTART;
		end else if (pick < 38) begin
			w.kind = KIND_ADD;
			if (sel < 8)
				w.seq_value = seq_pool[$urandom_range(0, POOL_SIZE - 1)];
		end else if (pick < 73) begin
			w.kind = KIND_REMOVE;
			// near the top of the implicit range, one step past it included
			if (sel < 4)
				w.seq_value = cur_own - 64'(cur_off) - 64'($urandom_range(0, 16));
			else if (sel < 9)
				w.seq_value = seq_pool[$urandom_range(0, POOL_SIZE - 1)];
		end else if (pick < 95) begin
			w.kind = KIND_GET;
			if (sel < 8)
				w.entry_index = 5'($urandom_range(0, 23));
		end
		return w;
	endfunction

	task automatic send_word(input udl_in_t w);
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [63:0] own, input logic [7:0] off,
			input logic [3:0] init, input bit spare);
		write_reg(CFG_OWN_SEQUENCE, own);
		write_reg(CFG_TYPE_OFFSET, ({$urandom, $urandom} & ~64'hff) | 64'(off));
		write_reg(CFG_IMPLICIT_INITIAL, ({$urandom, $urandom} & ~64'hf) | 64'(init));
		if (spare)
			write_reg(CFG_SPARE, {$urandom, $urandom});
		cfg_valid <= 1'b0;
		cur_own = own;
		cur_off = off;
		foreach (seq_pool[i])
			seq_pool[i] = (i < 8) ? {$urandom, $urandom} :
				own - 64'(off) - 64'(17 + $urandom_range(0, 40));
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic run_random(input int count);
		int burst;
		int gap;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			if (burst == 0) begin
				burst = $urandom_range(1, 16);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
				if ($urandom_range(0, 29) == 0) begin
					drain();
				end else if (gap > 0) begin
					start <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			send_word(random_dep_op());
			burst--;
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// implicit range 992..996 after restart
		set_config(64'd1000, 8'd3, 4'd5, 1'b1);
		send_word(dep_op(KIND_ADD, 64'd5, 5'd0));
		send_word(dep_op(KIND_RESTART, 64'd0, 5'd0));
		send_word(dep_op(KIND_GET, 64'd0, 5'd0));
		send_word(dep_op(KIND_GET, 64'd0, 5'd5));
		send_word(dep_op(KIND_REMOVE, 64'd0, 5'd0));
		send_word(dep_op(KIND_REMOVE, 64'd997, 5'd0));
		send_word(dep_op(KIND_REMOVE, 64'd992, 5'd0));
		send_word(dep_op(KIND_ADD, 64'd10, 5'd0));
		send_word(dep_op(KIND_ADD, 64'd20, 5'd0));
		send_word(dep_op(KIND_ADD, 64'd30, 5'd0));
		send_word(dep_op(KIND_ADD, 64'd40, 5'd0));
		send_word(dep_op(KIND_ADD, 64'd50, 5'd0));
		send_word(dep_op(KIND_ADD, 64'd60, 5'd0));
		send_word(dep_op(KIND_ADD, 64'd70, 5'd0));
		send_word(dep_op(KIND_ADD, 64'd30, 5'd0));
		send_word(dep_op(KIND_ADD, 64'd80, 5'd0));
		send_word(dep_op(KIND_ADD, 64'd90, 5'd0));
		send_word(dep_op(KIND_REMOVE, 64'd995, 5'd0));
		send_word(dep_op(KIND_REMOVE, 64'd80, 5'd0));
		send_word(dep_op(KIND_REMOVE, 64'd20, 5'd0));
		send_word(dep_op(KIND_REMOVE, 64'd55, 5'd0));
		send_word(dep_op(KIND_REMOVE, 64'd994, 5'd0));
		send_word(dep_op(KIND_GET, 64'd0, 5'd7));
		send_word(dep_op(KIND_GET, 64'd0, 5'd31));
		send_word(dep_op(KIND_ADD, '1, 5'd0));

		for (int p = 0; p < 5; p++) begin
			drain();
			case (p)
				0: set_config(64'd0, 8'd0, 4'd0, 1'b0);
				1: set_config('1, 8'hff, 4'hf, 1'b0);
				2: set_config({$urandom, $urandom}, 8'($urandom), 4'($urandom), 1'b1);
				3: set_config(64'd5, 8'd200, 4'hf, 1'b0);
				default: set_config({$urandom, $urandom}, 8'($urandom_range(0, 255)),
					4'($urandom_range(0, 15)), 1'b0);
			endcase
			run_random(PHASE_ITEMS);
		end

		drain();
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("tb_uop_dependency_list: PASS");
		else
			$display("tb_uop_dependency_list: FAIL");
		$finish;
	end

endmodule
